@@ rtl/core/load_based_dvfs_table_governor_macros.svh @@
// Assertion macros used by the governor back end (lbg_back).
`ifndef LOAD_BASED_DVFS_TABLE_GOVERNOR_MACROS_SVH
`define LOAD_BASED_DVFS_TABLE_GOVERNOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge of clk outside reset.
`define LBG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lbg assertion failed");

// Condition that must never be seen outside reset.
`define LBG_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lbg forbidden condition seen");

`else

`define LBG_ASSERT(label, prop)
`define LBG_NEVER(label, cond)

`endif

`endif

@@ rtl/core/lbg_pkg.sv @@
package lbg_pkg;

    // Field and datapath widths.
    localparam int FREQ_W     = 22;
    localparam int PCT_W      = 7;
    localparam int CORES_W    = 3;
    localparam int CORE_IDX_W = 2;
    localparam int TIME_W     = 64;
    localparam int DELTA_W    = 32;
    localparam int PROD_W     = DELTA_W + PCT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FREQ_W;

    // Highest number of cores that may be online.
    localparam int MAX_CORES = 4;

    // Depth of the work queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Result actions.
    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_SET_FREQ  = 2'd1,
        ACT_CORE_UP   = 2'd2,
        ACT_CORE_DOWN = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UP_TH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_TH_HP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TH_HP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGN_NICE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KHZ    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_KHZ    = 3'd7;

    // Down threshold offset.
    localparam logic [PCT_W-1:0] DOWN_MARGIN = 7'd10;

    // Configuration seen by the decision logic.
    typedef struct packed {
        logic [PCT_W-1:0]  rise_pct;
        logic [PCT_W-1:0]  rise_core_pct;
        logic [PCT_W-1:0]  fall_pct;
        logic [PCT_W-1:0]  fall_core_pct;
        logic [PCT_W-1:0]  boost_level;
        logic [FREQ_W-1:0] policy_max_khz;
        logic [FREQ_W-1:0] policy_min_khz;
    } cfg_t;

    // One queued job: scaled busy time, divisor and sample context.
    typedef struct packed {
        logic [PROD_W-1:0]  product;
        logic [DELTA_W-1:0] divisor;
        logic [FREQ_W-1:0]  cur_freq;
        logic [CORES_W-1:0] cores;
    } job_t;

    // Frequency step table.
    localparam int TBL_ROWS = 7;

    localparam logic [FREQ_W-1:0] TBL_FREQ [TBL_ROWS] = '{
        22'd1795000, 22'd1596000, 22'd1196000, 22'd798000,
        22'd624000,  22'd416000,  22'd208000
    };
    localparam logic [FREQ_W-1:0] TBL_SLOW_UP [TBL_ROWS] = '{
        22'd1795000, 22'd1795000, 22'd1596000, 22'd1196000,
        22'd798000,  22'd624000,  22'd416000
    };
    localparam logic [FREQ_W-1:0] TBL_FAST_UP [TBL_ROWS] = '{
        22'd1795000, 22'd1795000, 22'd1795000, 22'd1596000,
        22'd1196000, 22'd798000,  22'd624000
    };
    localparam logic [FREQ_W-1:0] TBL_DOWN [TBL_ROWS] = '{
        22'd1596000, 22'd1196000, 22'd798000, 22'd624000,
        22'd416000,  22'd208000,  22'd208000
    };

    // Next table step; a frequency not in the table is returned unchanged.
    function automatic logic [FREQ_W-1:0] table_step(
        input logic [FREQ_W-1:0] freq,
        input logic              step_up,
        input logic              fast
    );
        logic [FREQ_W-1:0] res;
        res = freq;
        for (int r = 0; r < TBL_ROWS; r++) begin
            if (TBL_FREQ[r] == freq) begin
                if (!step_up) begin
                    res = TBL_DOWN[r];
                end else if (fast) begin
                    res = TBL_FAST_UP[r];
                end else begin
                    res = TBL_SLOW_UP[r];
                end
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lbg_front.sv @@
module lbg_front
    import lbg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                nice_as_idle,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TIME_W-1:0]   wall_time_us,
    input  logic [TIME_W-1:0]   idle_time_us,
    input  logic [TIME_W-1:0]   nice_time_us,
    input  logic [FREQ_W-1:0]   current_freq_khz,
    input  logic [CORES_W-1:0]  online_cores,
    output logic                push,
    output job_t                push_job,
    input  logic                queue_full
);

    // Only the low 32 bits of the previous counters matter for the deltas.
    logic [DELTA_W-1:0] last_wall_reg, last_idle_reg, last_nice_reg;
    logic               s1_valid_reg;
    logic [DELTA_W-1:0] wall_d_reg, idle_d_reg;
    logic [FREQ_W-1:0]  cur_reg;
    logic [CORES_W-1:0] cores_reg;

    logic               accept;
    logic [DELTA_W-1:0] wall_d_next, idle_d_next, nice_d;
    logic [DELTA_W:0]   busy;
    logic               loaded;
    logic [PROD_W-1:0]  busy_ext, product;

    assign push     = s1_valid_reg && !queue_full;
    assign in_ready = !s1_valid_reg || push;
    assign accept   = in_valid && in_ready;

    // Counter deltas modulo 2^32, nice time folded into idle when enabled.
    always_comb
    begin
        wall_d_next = wall_time_us[DELTA_W-1:0] - last_wall_reg;
        nice_d      = nice_time_us[DELTA_W-1:0] - last_nice_reg;
        idle_d_next = idle_time_us[DELTA_W-1:0] - last_idle_reg;
        if (nice_as_idle)
        begin
            idle_d_next = idle_d_next + nice_d;
        end
    end

    // Previous counters and the delta stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_wall_reg <= '0;
            last_idle_reg <= '0;
            last_nice_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_wall_reg <= wall_time_us[DELTA_W-1:0];
                last_idle_reg <= idle_time_us[DELTA_W-1:0];
                if (nice_as_idle)
                begin
                    last_nice_reg <= nice_time_us[DELTA_W-1:0];
                end
                s1_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wall_d_reg <= wall_d_next;
            idle_d_reg <= idle_d_next;
            cur_reg    <= current_freq_khz;
            cores_reg  <= online_cores;
        end
    end

    // Busy time, the load test and busy time times 100 by shifts.
    always_comb
    begin
        busy     = {1'b0, wall_d_reg} - {1'b0, idle_d_reg};
        loaded   = !busy[DELTA_W] && (busy[DELTA_W-1:0] != '0);
        busy_ext = {{PCT_W{1'b0}}, busy[DELTA_W-1:0]};
        product  = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
        // An unloaded sample divides zero by all ones, giving zero.
        push_job.product  = loaded ? product : '0;
        push_job.divisor  = loaded ? wall_d_reg : '1;
        push_job.cur_freq = cur_reg;
        push_job.cores    = cores_reg;
    end

endmodule

@@ rtl/core/lbg_queue.sv @@
module lbg_queue
    import lbg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];

    // Storage; the front only pushes when not full.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/lbg_back.sv @@
`include "load_based_dvfs_table_governor_macros.svh"

module lbg_back
    import lbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  job_valid,
    input  job_t                  job,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            action,
    output logic [FREQ_W-1:0]     target_freq_khz,
    output logic [CORE_IDX_W-1:0] core_index,
    output logic [PCT_W-1:0]      load_percent
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [PROD_W-1:0]     rem_reg, dsh_reg;
    logic [PCT_W-1:0]      quot_reg;
    logic [2:0]            cnt_reg;
    logic [FREQ_W-1:0]     cur_reg;
    logic [CORES_W-1:0]    cores_reg;
    logic [FREQ_W-1:0]     requested_khz_reg;
    logic                  out_valid_reg;
    action_t               action_reg;
    logic [FREQ_W-1:0]     target_reg;
    logic [CORE_IDX_W-1:0] core_reg;
    logic [PCT_W-1:0]      load_reg;

    logic                  ge;
    logic                  out_load;
    logic                  fast, down_ok;
    logic [CORES_W-1:0]    cores_dn;
    action_t               act_dec;
    logic [FREQ_W-1:0]     target_dec;
    logic [CORE_IDX_W-1:0] core_dec;
    logic                  req_upd;

    assign pop      = (state_reg == ST_IDLE) && job_valid;
    assign ge       = (rem_reg >= dsh_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer: take a job, seven restoring divide steps, then decide.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider: the quotient never exceeds 100, so seven bits suffice.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg   <= job.product;
            dsh_reg   <= {1'b0, job.divisor, 6'b0};
            cnt_reg   <= 3'd6;
            quot_reg  <= '0;
            cur_reg   <= job.cur_freq;
            cores_reg <= job.cores;
        end
        else if (state_reg == ST_DIV)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[PCT_W-2:0], ge};
            cnt_reg  <= cnt_reg - 3'd1;
        end
    end

    // Decision: step up, core up, step down or core down, in that order.
    always_comb
    begin
        fast       = (quot_reg >= cfg.boost_level);
        down_ok    = (cfg.fall_pct < DOWN_MARGIN) ||
                     (quot_reg < (cfg.fall_pct - DOWN_MARGIN));
        cores_dn   = cores_reg - 3'd1;
        act_dec    = ACT_NONE;
        target_dec = '0;
        core_dec   = '0;
        req_upd    = 1'b0;
        priority if ((quot_reg > cfg.rise_pct) &&
                     (requested_khz_reg != cfg.policy_max_khz))
        begin
            act_dec    = ACT_SET_FREQ;
            target_dec = table_step(cur_reg, 1'b1, fast);
            req_upd    = 1'b1;
        end
        else if ((cores_reg < CORES_W'(MAX_CORES)) &&
                 (quot_reg > cfg.rise_core_pct))
        begin
            act_dec  = ACT_CORE_UP;
            core_dec = cores_reg[CORE_IDX_W-1:0];
        end
        else if (down_ok && (cur_reg != cfg.policy_min_khz))
        begin
            act_dec    = ACT_SET_FREQ;
            target_dec = table_step(cur_reg, 1'b0, fast);
            req_upd    = 1'b1;
        end
        else if ((cores_reg > 3'd1) && (quot_reg < cfg.fall_core_pct))
        begin
            act_dec  = ACT_CORE_DOWN;
            core_dec = cores_dn[CORE_IDX_W-1:0];
        end
        else
        begin
            // Nothing to do for this sample.
            act_dec = ACT_NONE;
        end
    end

    // Requested frequency and output word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_khz_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_load && req_upd)
            begin
                requested_khz_reg <= target_dec;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            action_reg <= act_dec;
            target_reg <= target_dec;
            core_reg   <= core_dec;
            load_reg   <= quot_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign target_freq_khz = target_reg;
    assign core_index      = core_reg;
    assign load_percent    = load_reg;

    // The divider always produces a percentage within range.
    `LBG_NEVER(a_load_range, (state_reg == ST_DONE) && (quot_reg > 7'd100))
    // The requested frequency moves only when a result is written out.
    `LBG_ASSERT(a_req_hold, !out_load |=> $stable(requested_khz_reg))
    // A job is only taken while the sequencer is idle.
    `LBG_ASSERT(a_pop_idle, pop |=> (state_reg == ST_DIV))

endmodule

@@ rtl/core/load_based_dvfs_table_governor.sv @@
// Channel | Direction | Handshake              | Words
// sample  | in        | in_valid / in_ready    | wall, idle, nice times, freq, cores
// result  | out       | out_valid / out_ready  | action, target freq, core, load
// config  | in        | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// A sample passes the delta stage, the queue, seven restoring divider steps and a
// decision state before its result is valid; the back takes a new sample only
// once the result of the last one is in the output register.
// A two-word queue and the output register let the front run ahead; a stalled
// result side fills them and in_ready then falls.
// Reset clears the previous counters, the requested frequency and all handshake state.
module load_based_dvfs_table_governor
    import lbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_W-1:0]     wall_time_us,
    input  logic [TIME_W-1:0]     idle_time_us,
    input  logic [TIME_W-1:0]     nice_time_us,
    input  logic [FREQ_W-1:0]     current_freq_khz,
    input  logic [CORES_W-1:0]    online_cores,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            action,
    output logic [FREQ_W-1:0]     target_freq_khz,
    output logic [CORE_IDX_W-1:0] core_index,
    output logic [PCT_W-1:0]      load_percent
);

    cfg_t cfg_reg;
    logic nice_as_idle_reg;
    logic push, queue_full, pop, job_valid;
    job_t push_job, pop_job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_pct       <= 7'd60;
            cfg_reg.rise_core_pct  <= 7'd75;
            cfg_reg.fall_pct       <= 7'd25;
            cfg_reg.fall_core_pct  <= 7'd15;
            cfg_reg.boost_level    <= 7'd85;
            cfg_reg.policy_max_khz <= 22'd1795000;
            cfg_reg.policy_min_khz <= 22'd208000;
            nice_as_idle_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UP_TH:      cfg_reg.rise_pct       <= cfg_wdata[PCT_W-1:0];
                CFG_UP_TH_HP:   cfg_reg.rise_core_pct  <= cfg_wdata[PCT_W-1:0];
                CFG_DOWN_TH:    cfg_reg.fall_pct       <= cfg_wdata[PCT_W-1:0];
                CFG_DOWN_TH_HP: cfg_reg.fall_core_pct  <= cfg_wdata[PCT_W-1:0];
                CFG_IGN_NICE:   nice_as_idle_reg       <= cfg_wdata[0];
                CFG_BOOST:      cfg_reg.boost_level    <= cfg_wdata[PCT_W-1:0];
                CFG_MAX_KHZ:    cfg_reg.policy_max_khz <= cfg_wdata[FREQ_W-1:0];
                CFG_MIN_KHZ:    cfg_reg.policy_min_khz <= cfg_wdata[FREQ_W-1:0];
                default:        ;
            endcase
        end
    end

    // Front: counter deltas and scaled busy time.
    lbg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .nice_as_idle     (nice_as_idle_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .wall_time_us     (wall_time_us),
        .idle_time_us     (idle_time_us),
        .nice_time_us     (nice_time_us),
        .current_freq_khz (current_freq_khz),
        .online_cores     (online_cores),
        .push             (push),
        .push_job         (push_job),
        .queue_full       (queue_full)
    );

    // Short queue between front and back.
    lbg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (job_valid),
        .pop_job   (pop_job)
    );

    // Back: load division, decision and output register.
    lbg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .job_valid       (job_valid),
        .job             (pop_job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .target_freq_khz (target_freq_khz),
        .core_index      (core_index),
        .load_percent    (load_percent)
    );

endmodule

@@ verif/load_based_dvfs_table_governor_tb.sv @@
`timescale 1ns / 100ps

module load_based_dvfs_table_governor_tb;
    import lbg_pkg::*;

    localparam int NUM_REGS      = 8;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 15;
    localparam int LADDER_ROWS   = 7;

    // Frequency ladder: each step, the next step up on either table and the step down.
    localparam logic [FREQ_W-1:0] LADDER_KHZ [LADDER_ROWS] = '{
        22'd1795000, 22'd1596000, 22'd1196000, 22'd798000,
        22'd624000,  22'd416000,  22'd208000
    };
    localparam logic [FREQ_W-1:0] LADDER_SLOW_UP [LADDER_ROWS] = '{
        22'd1795000, 22'd1795000, 22'd1596000, 22'd1196000,
        22'd798000,  22'd624000,  22'd416000
    };
    localparam logic [FREQ_W-1:0] LADDER_FAST_UP [LADDER_ROWS] = '{
        22'd1795000, 22'd1795000, 22'd1795000, 22'd1596000,
        22'd1196000, 22'd798000,  22'd624000
    };
    localparam logic [FREQ_W-1:0] LADDER_DOWN [LADDER_ROWS] = '{
        22'd1596000, 22'd1196000, 22'd798000, 22'd624000,
        22'd416000,  22'd208000,  22'd208000
    };

    typedef struct packed {
        logic [TIME_W-1:0]  wall;
        logic [TIME_W-1:0]  idle;
        logic [TIME_W-1:0]  nice;
        logic [FREQ_W-1:0]  freq;
        logic [CORES_W-1:0] cores;
    } sample_t;

    typedef struct packed {
        action_t                action;
        logic [FREQ_W-1:0]      target;
        logic [CORE_IDX_W-1:0]  core;
        logic [PCT_W-1:0]       load;
    } decision_t;

    // One row of the directed plan: a register write or a sample word.
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        sample_t               smp;
        bit                    has_known;
        decision_t             known;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [TIME_W-1:0]     wall_time_us;
    logic [TIME_W-1:0]     idle_time_us;
    logic [TIME_W-1:0]     nice_time_us;
    logic [FREQ_W-1:0]     current_freq_khz;
    logic [CORES_W-1:0]    online_cores;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            action;
    logic [FREQ_W-1:0]     target_freq_khz;
    logic [CORE_IDX_W-1:0] core_index;
    logic [PCT_W-1:0]      load_percent;

    // Governor settings as the predictor sees them.
    logic [PCT_W-1:0]  up_pct;
    logic [PCT_W-1:0]  up_hotplug_pct;
    logic [PCT_W-1:0]  down_pct;
    logic [PCT_W-1:0]  down_hotplug_pct;
    logic              count_nice;
    logic [PCT_W-1:0]  boost_pct;
    logic [FREQ_W-1:0] max_khz;
    logic [FREQ_W-1:0] min_khz;

    // Counters from the previous sample and the last frequency asked for.
    logic [TIME_W-1:0] prev_wall;
    logic [TIME_W-1:0] prev_idle;
    logic [TIME_W-1:0] prev_nice;
    logic [FREQ_W-1:0] held_khz;

    decision_t   expected_decisions[$];
    plan_row_t   plan[$];
    int          mismatch_count;
    int          cycle_count;
    int          holds_asked;
    bit          quiet;

    load_based_dvfs_table_governor i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .wall_time_us     (wall_time_us),
        .idle_time_us     (idle_time_us),
        .nice_time_us     (nice_time_us),
        .current_freq_khz (current_freq_khz),
        .online_cores     (online_cores),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .target_freq_khz  (target_freq_khz),
        .core_index       (core_index),
        .load_percent     (load_percent)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Next frequency on the ladder; an unknown frequency stays where it is.
    function automatic logic [FREQ_W-1:0] ladder_step(
        input logic [FREQ_W-1:0] freq,
        input bit                up,
        input bit                fast
    );
        logic [FREQ_W-1:0] nxt;
        nxt = freq;
        for (int r = LADDER_ROWS - 1; r >= 0; r--)
        begin
            if (LADDER_KHZ[r] == freq)
            begin
                if (!up)
                    nxt = LADDER_DOWN[r];
                else if (fast)
                    nxt = LADDER_FAST_UP[r];
                else
                    nxt = LADDER_SLOW_UP[r];
            end
        end
        return nxt;
    endfunction

    // Works out the governor's decision for one sample and advances its state.
    function automatic decision_t governor_decide(input sample_t s);
        decision_t   d;
        logic [31:0] wall_d;
        logic [31:0] idle_d;
        logic [31:0] busy_pct;
        logic [63:0] scaled;
        bit          fast;
        bit          down_ok;
        d = '0;
        wall_d = s.wall[31:0] - prev_wall[31:0];
        prev_wall = s.wall;
        idle_d = s.idle[31:0] - prev_idle[31:0];
        prev_idle = s.idle;
        if (count_nice)
        begin
            idle_d = idle_d + (s.nice[31:0] - prev_nice[31:0]);
            prev_nice = s.nice;
        end

        // Busy share of the wall delta, product kept wide.
        busy_pct = 32'd0;
        if (wall_d != 32'd0 && wall_d > idle_d)
        begin
            scaled = 64'd100 * {32'd0, wall_d - idle_d};
            busy_pct = 32'(scaled / {32'd0, wall_d});
        end

        // A down threshold under ten makes the unsigned margin wrap, so the test always holds.
        down_ok = (down_pct < 7'd10) ? 1'b1 : (busy_pct < 32'(down_pct) - 32'd10);
        fast = busy_pct >= 32'(boost_pct);

        if (busy_pct > 32'(up_pct) && held_khz != max_khz)
        begin
            held_khz = ladder_step(s.freq, 1'b1, fast);
            d.action = ACT_SET_FREQ;
            d.target = held_khz;
        end
        else if (s.cores < MAX_CORES && busy_pct > 32'(up_hotplug_pct))
        begin
            d.action = ACT_CORE_UP;
            d.core = s.cores[1:0];
        end
        else if (down_ok && s.freq != min_khz)
        begin
            held_khz = ladder_step(s.freq, 1'b0, fast);
            d.action = ACT_SET_FREQ;
            d.target = held_khz;
        end
        else if (s.cores > 3'd1 && busy_pct < 32'(down_hotplug_pct))
        begin
            d.action = ACT_CORE_DOWN;
            d.core = s.cores[1:0] - 2'd1;
        end
        d.load = busy_pct[PCT_W-1:0];
        return d;
    endfunction

    function automatic void add_write(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        plan_row_t row;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.smp = '0;
        row.has_known = 1'b0;
        row.known = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_sample(
        input logic [TIME_W-1:0]  w,
        input logic [TIME_W-1:0]  i,
        input logic [TIME_W-1:0]  n,
        input logic [FREQ_W-1:0]  f,
        input logic [CORES_W-1:0] c
    );
        plan_row_t row;
        row.is_write = 1'b0;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.smp = '{wall: w, idle: i, nice: n, freq: f, cores: c};
        row.has_known = 1'b0;
        row.known = '0;
        plan.push_back(row);
    endfunction

    // A sample whose decision is plain from the settings after reset.
    function automatic void add_known(
        input logic [TIME_W-1:0]     w,
        input logic [TIME_W-1:0]     i,
        input logic [TIME_W-1:0]     n,
        input logic [FREQ_W-1:0]     f,
        input logic [CORES_W-1:0]    c,
        input action_t               a,
        input logic [FREQ_W-1:0]     t,
        input logic [CORE_IDX_W-1:0] k,
        input logic [PCT_W-1:0]      l
    );
        add_sample(w, i, n, f, c);
        plan[$].has_known = 1'b1;
        plan[$].known = '{action: a, target: t, core: k, load: l};
    endfunction

    function automatic logic [PCT_W-1:0] pick_pct();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd100;
            2: return PCT_W'($urandom_range(0, 9));
            3: return PCT_W'($urandom_range(101, 127));
            default: return PCT_W'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_khz();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return FREQ_W'($urandom_range(0, 22'h3FFFFF));
            default: return LADDER_KHZ[$urandom_range(0, LADDER_ROWS - 1)];
        endcase
    endfunction

    // Register writes happen only with nothing in flight.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_UP_TH:      up_pct = val[PCT_W-1:0];
            CFG_UP_TH_HP:   up_hotplug_pct = val[PCT_W-1:0];
            CFG_DOWN_TH:    down_pct = val[PCT_W-1:0];
            CFG_DOWN_TH_HP: down_hotplug_pct = val[PCT_W-1:0];
            CFG_IGN_NICE:   count_nice = val[0];
            CFG_BOOST:      boost_pct = val[PCT_W-1:0];
            CFG_MAX_KHZ:    max_khz = val[FREQ_W-1:0];
            CFG_MIN_KHZ:    min_khz = val[FREQ_W-1:0];
            default:        ;
        endcase
    endtask

    // Offers one sample word, with random gaps, and records its decision once taken.
    task automatic offer_sample(input sample_t s, input bit has_known, input decision_t known);
        decision_t predicted;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        wall_time_us <= s.wall;
        idle_time_us <= s.idle;
        nice_time_us <= s.nice;
        current_freq_khz <= s.freq;
        online_cores <= s.cores;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = governor_decide(s);
        expected_decisions.push_back(has_known ? known : predicted);
    endtask

    // Stops offering and waits until every decision has come back.
    task automatic wait_for_decisions();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, plus long hold-offs when asked for.
    initial
    begin
        int holds_done;
        holds_done = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Each decision word taken is checked against the oldest outstanding one.
    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("decision with none outstanding: action %0d load_percent %0d",
                       action, load_percent);
                mismatch_count++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    mismatch_count++;
                end
                if (target_freq_khz !== want.target)
                begin
                    $error("target_freq_khz: expected %0d, got %0d",
                           want.target, target_freq_khz);
                    mismatch_count++;
                end
                if (core_index !== want.core)
                begin
                    $error("core_index: expected %0d, got %0d", want.core, core_index);
                    mismatch_count++;
                end
                if (load_percent !== want.load)
                begin
                    $error("load_percent: expected %0d, got %0d", want.load, load_percent);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL load_based_dvfs_table_governor");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] setting [NUM_REGS];
        logic [TIME_W-1:0]     acc_wall;
        logic [TIME_W-1:0]     acc_idle;
        logic [TIME_W-1:0]     acc_nice;
        int unsigned           step_wall;
        int unsigned           step_idle;
        int unsigned           step_nice;
        int unsigned           roll;
        sample_t               s;
        bit                    in_flight;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        wall_time_us = '0;
        idle_time_us = '0;
        nice_time_us = '0;
        current_freq_khz = '0;
        online_cores = '0;
        mismatch_count = 0;
        holds_asked = 0;
        quiet = 1'b0;
        in_flight = 1'b0;
        acc_wall = '0;
        acc_idle = '0;
        acc_nice = '0;

        // Settings and history as they stand after reset.
        up_pct = 7'd60;
        up_hotplug_pct = 7'd75;
        down_pct = 7'd25;
        down_hotplug_pct = 7'd15;
        count_nice = 1'b0;
        boost_pct = 7'd85;
        max_khz = 22'd1795000;
        min_khz = 22'd208000;
        prev_wall = '0;
        prev_idle = '0;
        prev_nice = '0;
        held_khz = '0;

        // Directed plan. First rows run on the reset settings.
        // Idle sample at the floor with four cores: the top core goes down.
        add_known(0, 0, 0, 22'd208000, 4, ACT_CORE_DOWN, 0, 3, 0);
        // Full load from nothing requested: step up on the fast table.
        add_known(1000, 0, 0, 22'd1795000, 1, ACT_SET_FREQ, 22'd1795000, 0, 100);
        // Full load already at the ceiling: a core comes up instead.
        add_known(2000, 0, 0, 22'd1596000, 2, ACT_CORE_UP, 0, 2, 100);
        add_known(3000, 1000, 0, 22'd1596000, 1, ACT_SET_FREQ, 22'd1196000, 0, 0);
        // At the floor with one core: nothing to do.
        add_known(4000, 2000, 0, 22'd208000, 1, ACT_NONE, 0, 0, 0);
        // Frequency off the ladder is asked for unchanged.
        add_known(5000, 2000, 0, 22'd1234567, 1, ACT_SET_FREQ, 22'd1234567, 0, 100);
        add_known(6000, 2500, 0, 22'd798000, 3, ACT_NONE, 0, 0, 50);
        add_sample(7000, 2890, 0, 22'd798000, 3);
        add_sample(8000, 3040, 0, 22'd798000, 3);
        add_sample(9000, 3200, 0, 22'd624000, 3);
        // Idle delta beyond the wall delta.
        add_sample(10000, 5200, 0, 22'd208000, 4);
        // Field extremes and counter wrap.
        add_sample('1, '1, '1, '1, 7);
        add_sample(0, 0, 0, 0, 0);
        // Wall delta vanishes once cut to 32 bits.
        add_sample(64'h1_0000_0000, 64'h1_0000_0000, 64'h5, '1, 6);
        // Nice time counted, small down threshold, zero up threshold, fast table everywhere.
        add_write(CFG_IGN_NICE, 1);
        add_write(CFG_DOWN_TH, 5);
        add_write(CFG_BOOST, 1);
        add_write(CFG_UP_TH, 0);
        add_sample(64'h1_0000_1000, 64'h1_0000_0200, 64'h12C, 22'd1196000, 1);
        add_sample(64'h1_0000_2000, 64'h1_0000_0300, 64'h2000, 22'd416000, 4);
        add_sample(64'h1_0000_3000, 64'h1_0000_0400, 64'h2100, 22'd208000, 2);
        // Widest policy limits, never stepping up, hotplug on any load.
        add_write(CFG_MAX_KHZ, 22'h3FFFFF);
        add_write(CFG_MIN_KHZ, 0);
        add_write(CFG_UP_TH, 127);
        add_write(CFG_UP_TH_HP, 0);
        add_write(CFG_DOWN_TH_HP, 100);
        add_write(CFG_IGN_NICE, 0);
        add_sample(64'h1_0000_4000, 64'h1_0000_0500, 64'h1, 0, 0);
        add_sample(64'h1_0000_5000, 64'h1_0000_1000, 64'h1, 22'd1596000, 4);
        add_sample(64'h1_0000_6000, 64'h1_0000_1F00, 64'h1, '1, 5);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].is_write)
            begin
                if (in_flight)
                    wait_for_decisions();
                in_flight = 1'b0;
                write_register(plan[k].reg_idx, plan[k].reg_val);
            end
            else
            begin
                offer_sample(plan[k].smp, plan[k].has_known, plan[k].known);
                in_flight = 1'b1;
            end
        end
        acc_wall = 64'h1_0000_6000;
        acc_idle = 64'h1_0000_1F00;
        acc_nice = 64'h1;

        // Random phases, each under its own settings.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_decisions();
            case (phase)
                0:
                begin
                    setting[CFG_UP_TH] = 60;
                    setting[CFG_UP_TH_HP] = 75;
                    setting[CFG_DOWN_TH] = 25;
                    setting[CFG_DOWN_TH_HP] = 15;
                    setting[CFG_IGN_NICE] = 0;
                    setting[CFG_BOOST] = 85;
                    setting[CFG_MAX_KHZ] = 1795000;
                    setting[CFG_MIN_KHZ] = 208000;
                end
                1:
                begin
                    setting[CFG_UP_TH] = 0;
                    setting[CFG_UP_TH_HP] = 0;
                    setting[CFG_DOWN_TH] = 1;
                    setting[CFG_DOWN_TH_HP] = 0;
                    setting[CFG_IGN_NICE] = 1;
                    setting[CFG_BOOST] = 1;
                    setting[CFG_MAX_KHZ] = 0;
                    setting[CFG_MIN_KHZ] = 0;
                end
                2:
                begin
                    setting[CFG_UP_TH] = 100;
                    setting[CFG_UP_TH_HP] = 100;
                    setting[CFG_DOWN_TH] = 100;
                    setting[CFG_DOWN_TH_HP] = 100;
                    setting[CFG_IGN_NICE] = 0;
                    setting[CFG_BOOST] = 100;
                    setting[CFG_MAX_KHZ] = 1795000;
                    setting[CFG_MIN_KHZ] = 208000;
                end
                3:
                begin
                    setting[CFG_UP_TH] = 127;
                    setting[CFG_UP_TH_HP] = 127;
                    setting[CFG_DOWN_TH] = 127;
                    setting[CFG_DOWN_TH_HP] = 127;
                    setting[CFG_IGN_NICE] = 1;
                    setting[CFG_BOOST] = 127;
                    setting[CFG_MAX_KHZ] = 22'h3FFFFF;
                    setting[CFG_MIN_KHZ] = 22'h3FFFFF;
                end
                default:
                begin
                    setting[CFG_UP_TH] = pick_pct();
                    setting[CFG_UP_TH_HP] = pick_pct();
                    setting[CFG_DOWN_TH] = pick_pct();
                    setting[CFG_DOWN_TH_HP] = pick_pct();
                    setting[CFG_IGN_NICE] = CFG_DATA_W'($urandom_range(0, 1));
                    setting[CFG_BOOST] = pick_pct();
                    setting[CFG_MAX_KHZ] = pick_khz();
                    setting[CFG_MIN_KHZ] = pick_khz();
                end
            endcase
            for (int r = 0; r < NUM_REGS; r++)
                write_register(CFG_IDX_W'(r), setting[r]);

            // One phase fills the block behind a long result stall, one runs flat out.
            if (phase == 2)
                holds_asked++;
            quiet = (phase == 4);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 6 && n == PHASE_ITEMS / 2)
                    wait_for_decisions();

                // Mostly steady counters; some noise, idle overruns and huge jumps.
                roll = $urandom_range(0, 99);
                step_wall = $urandom_range(0, 20000);
                step_idle = $urandom_range(0, step_wall);
                step_nice = $urandom_range(0, step_wall - step_idle);
                if (roll < 3)
                    step_wall = 0;
                else if (roll < 9)
                    step_idle = step_wall + $urandom_range(1, 5000);
                else if (roll < 13)
                begin
                    step_wall = $urandom;
                    step_idle = $urandom_range(0, step_wall);
                    step_nice = $urandom;
                end
                if (roll >= 94)
                begin
                    acc_wall = {$urandom, $urandom};
                    acc_idle = {$urandom, $urandom};
                    acc_nice = {$urandom, $urandom};
                end
                else
                begin
                    acc_wall = acc_wall + step_wall;
                    acc_idle = acc_idle + step_idle;
                    acc_nice = acc_nice + step_nice;
                end
                s.wall = acc_wall;
                s.idle = acc_idle;
                s.nice = acc_nice;
                case ($urandom_range(0, 9))
                    6: s.freq = min_khz;
                    7: s.freq = max_khz;
                    8: s.freq = held_khz;
                    9: s.freq = FREQ_W'($urandom_range(0, 22'h3FFFFF));
                    default: s.freq = LADDER_KHZ[$urandom_range(0, LADDER_ROWS - 1)];
                endcase
                if ($urandom_range(0, 99) < 85)
                    s.cores = CORES_W'($urandom_range(1, MAX_CORES));
                else
                    s.cores = CORES_W'($urandom_range(0, 7));
                offer_sample(s, 1'b0, '0);
            end
            quiet = 1'b0;
        end

        wait_for_decisions();
        if (mismatch_count == 0 && expected_decisions.size() == 0)
            $display("PASS load_based_dvfs_table_governor");
        else
            $display("FAIL load_based_dvfs_table_governor");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lbg_pkg.sv
rtl/core/lbg_front.sv
rtl/core/lbg_queue.sv
rtl/core/lbg_back.sv
rtl/core/load_based_dvfs_table_governor.sv
verif/load_based_dvfs_table_governor_tb.sv
